// ===== rtl/deq_pkg.sv =====
// deq_pkg: shared constants, request and status codes, and the decoded
// operation type for the double-ended queue.
// No dependencies; compiled first.
package deq_pkg;

	// default geometry
	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// field widths fixed by the request and response formats
	localparam int REQ_W    = 3;
	localparam int STATUS_W = 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_REVERSE    = 3'd4;
	localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// one decoded transaction, in physical ring terms
	typedef struct packed {
		logic                put_first;
		logic                put_last;
		logic                take_first;
		logic                take_last;
		logic                flip;
		logic                clr;
		logic [STATUS_W-1:0] status;
	} deq_op_t;

endpackage

// ===== rtl/deq_if.sv =====
// deq_req_if / deq_rsp_if: valid-ready channels for requests and results.
// Depends on deq_pkg for the code widths and the default geometry.
interface deq_req_if
	import deq_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic [REQ_W-1:0]             req_type;
	logic signed [DATA_WIDTH-1:0] data_in;

	modport source (output valid, req_type, data_in, input ready);
	modport sink   (input valid, req_type, data_in, output ready);
	modport mon    (input valid, ready, req_type, data_in);
endinterface

interface deq_rsp_if
	import deq_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int CNT_W      = $clog2(DEPTH_DEF + 1)
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] popped_word;
	logic [STATUS_W-1:0]          status;
	logic [CNT_W-1:0]             entry_count;
	logic signed [DATA_WIDTH-1:0] front_word;
	logic signed [DATA_WIDTH-1:0] back_word;

	modport source (output valid, popped_word, status, entry_count, front_word, back_word,
		input ready);
	modport sink   (input valid, popped_word, status, entry_count, front_word, back_word,
		output ready);
	modport mon    (input valid, ready, popped_word, status, entry_count, front_word,
		back_word);
endinterface

// ===== rtl/double_ended_queue_with_reverse.sv =====
// double_ended_queue_with_reverse: top level, request channel in, result
// register out. Depends on deq_pkg, deq_if and deq_ring.
//
// Usage:
//   req  : valid-ready channel carrying req_type and data_in. Codes are push
//          back, push front, pop back, pop front, reverse and clear; codes
//          six and seven leave the queue alone.
//   rsp  : valid-ready channel, one result per request: popped_word, status
//          (ok, pop on empty, push on full), entry_count, front_word and
//          back_word after the request. The end words read zero when empty.
//   A request's result is registered and shows from the cycle after it is
//   accepted. One request per cycle is taken while the result register is
//   empty or being taken; the ring state, the two end-word registers and
//   the neighbor prefetch from the word memory all update in the accept cycle.
//   Reverse only toggles a direction flag and moves no words.
//   The result register holds one result; req.ready is high while it is
//   empty or being taken, so a stalled receiver stalls the request side
//   after a single result is waiting.
//   Reset leaves the queue empty and unreversed; memory contents are not
//   cleared and no clearing pass is needed.
module double_ended_queue_with_reverse
	import deq_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int CNT_W      = $clog2(DEPTH + 1)
) (
	input  logic      clk,
	input  logic      arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);

	logic                         accept;
	logic                         rsp_valid_q;
	logic signed [DATA_WIDTH-1:0] popped_nx, front_nx, back_nx;
	logic [STATUS_W-1:0]          status_nx;
	logic [CNT_W-1:0]             count_nx;
	logic signed [DATA_WIDTH-1:0] popped_q, front_q, back_q;
	logic [STATUS_W-1:0]          status_q;
	logic [CNT_W-1:0]             count_q;

	// request handshake
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	deq_ring #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.CNT_W      (CNT_W)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (accept),
		.req_type  (req.req_type),
		.word      (req.data_in),
		.popped_nx (popped_nx),
		.status_nx (status_nx),
		.count_nx  (count_nx),
		.front_nx  (front_nx),
		.back_nx   (back_nx)
	);

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q <= popped_nx;
			status_q <= status_nx;
			count_q  <= count_nx;
			front_q  <= front_nx;
			back_q   <= back_nx;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.popped_word = popped_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = count_q;
	assign rsp.front_word  = front_q;
	assign rsp.back_word   = back_q;

endmodule

// ===== rtl/deq_ram.sv =====
// deq_ram: generic memory, one write port and two registered read ports.
// A read of the address written in the same cycle returns the old data.
// No dependencies.
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== rtl/deq_dec.sv =====
// deq_dec: maps a request onto physical ring operations and a status,
// given the fill state and the direction flag.
// Depends on deq_pkg.
module deq_dec
	import deq_pkg::*;
(
	input  logic             en,
	input  logic [REQ_W-1:0] req_type,
	input  logic             empty,
	input  logic             full,
	input  logic             rev,
	output deq_op_t          op
);

	always_comb begin
		op = '0;
		op.status = ST_OK;
		if (en) begin
			case (req_type)
				REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
					if (full) begin
						op.status = ST_FULL;
					end else if ((req_type == REQ_PUSH_FRONT) != rev) begin
						op.put_first = 1'b1;
					end else begin
						op.put_last = 1'b1;
					end
				end
				REQ_POP_BACK, REQ_POP_FRONT: begin
					if (empty) begin
						op.status = ST_EMPTY;
					end else if ((req_type == REQ_POP_FRONT) != rev) begin
						op.take_first = 1'b1;
					end else begin
						op.take_last = 1'b1;
					end
				end
				REQ_REVERSE: begin
					op.flip = 1'b1;
				end
				REQ_CLEAR: begin
					op.clr = 1'b1;
				end
				default: begin
					op.status = ST_OK;
				end
			endcase
		end
	end

endmodule

// ===== rtl/deq_ring.sv =====
// deq_ring: ring state (head, tail, count, direction), end-word registers,
// and the word memory with prefetch of the two inner neighbors.
// Depends on deq_pkg, deq_dec and deq_ram.
module deq_ring
	import deq_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int CNT_W      = $clog2(DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [REQ_W-1:0]             req_type,
	input  logic signed [DATA_WIDTH-1:0] word,
	output logic signed [DATA_WIDTH-1:0] popped_nx,
	output logic [STATUS_W-1:0]          status_nx,
	output logic [CNT_W-1:0]             count_nx,
	output logic signed [DATA_WIDTH-1:0] front_nx,
	output logic signed [DATA_WIDTH-1:0] back_nx
);

	localparam int IDX_W = $clog2(DEPTH);

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		idx_inc = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
		idx_dec = (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

	logic [IDX_W-1:0]             head_q, tail_q, head_nx, tail_nx;
	logic [CNT_W-1:0]             count_q;
	logic                         rev_q, rev_nx;
	logic signed [DATA_WIDTH-1:0] first_q, last_q, first_nx, last_nx;
	logic                         byp_a_q, byp_b_q;
	logic signed [DATA_WIDTH-1:0] byp_word_q;
	logic [DATA_WIDTH-1:0]        ram_a, ram_b;
	logic signed [DATA_WIDTH-1:0] second_w, penult_w;
	logic                         we;
	logic [IDX_W-1:0]             waddr, raddr_a, raddr_b;
	deq_op_t                      op;

	// request decode
	deq_dec u_dec (
		.en       (en),
		.req_type (req_type),
		.empty    (count_q == '0),
		.full     (count_q == CNT_W'(DEPTH)),
		.rev      (rev_q),
		.op       (op)
	);

	// inner neighbors of the ends, with same-cycle write forwarding
	assign second_w = byp_a_q ? byp_word_q : $signed(ram_a);
	assign penult_w = byp_b_q ? byp_word_q : $signed(ram_b);

	// next ring state
	always_comb begin
		head_nx  = head_q;
		tail_nx  = tail_q;
		count_nx = count_q;
		first_nx = first_q;
		last_nx  = last_q;
		rev_nx   = rev_q;
		if (op.put_first) begin
			head_nx  = idx_dec(head_q);
			count_nx = count_q + 1'b1;
			first_nx = word;
			if (count_q == '0) begin
				last_nx = word;
			end
		end
		if (op.put_last) begin
			tail_nx  = idx_inc(tail_q);
			count_nx = count_q + 1'b1;
			last_nx  = word;
			if (count_q == '0) begin
				first_nx = word;
			end
		end
		if (op.take_first) begin
			head_nx  = idx_inc(head_q);
			count_nx = count_q - 1'b1;
			first_nx = second_w;
		end
		if (op.take_last) begin
			tail_nx  = idx_dec(tail_q);
			count_nx = count_q - 1'b1;
			last_nx  = penult_w;
		end
		if (op.flip) begin
			rev_nx = ~rev_q;
		end
		if (op.clr) begin
			head_nx  = '0;
			tail_nx  = IDX_W'(DEPTH - 1);
			count_nx = '0;
			rev_nx   = 1'b0;
		end
	end

	// memory access: write the new end, prefetch neighbors of the next ends
	assign we      = op.put_first | op.put_last;
	assign waddr   = op.put_first ? head_nx : tail_nx;
	assign raddr_a = idx_inc(head_nx);
	assign raddr_b = idx_dec(tail_nx);

	deq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (word),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (ram_a),
		.rdata_b (ram_b)
	);

	// result fields
	always_comb begin
		popped_nx = '0;
		if (op.take_first) begin
			popped_nx = first_q;
		end else if (op.take_last) begin
			popped_nx = last_q;
		end
		status_nx = op.status;
		if (count_nx == '0) begin
			front_nx = '0;
			back_nx  = '0;
		end else begin
			front_nx = rev_nx ? last_nx : first_nx;
			back_nx  = rev_nx ? first_nx : last_nx;
		end
	end

	// ring control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= IDX_W'(DEPTH - 1);
			count_q <= '0;
			rev_q   <= 1'b0;
			byp_a_q <= 1'b0;
			byp_b_q <= 1'b0;
		end else begin
			head_q  <= head_nx;
			tail_q  <= tail_nx;
			count_q <= count_nx;
			rev_q   <= rev_nx;
			byp_a_q <= we && (waddr == raddr_a);
			byp_b_q <= we && (waddr == raddr_b);
		end
	end

	// end words and forwarded write data
	always_ff @(posedge clk) begin
		first_q    <= first_nx;
		last_q     <= last_nx;
		byp_word_q <= word;
	end

endmodule

// ===== rtl/deq_chk.sv =====
// deq_chk: port-level checks on the queue's request and result channels,
// bound to the top level. Depends on deq_pkg and deq_if.
module deq_chk
	import deq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);

	// a waiting result stays until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid)
		else $error("result dropped while stalled");

	// every accepted request yields a result on the next cycle
	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> rsp.valid)
		else $error("accepted request gave no result");

	// pop on empty leaves an empty queue and no word
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_EMPTY) |->
		(rsp.entry_count == '0) && (rsp.popped_word == '0))
		else $error("empty status with words held");

	// push on full reports a full queue
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_FULL) |->
		(rsp.entry_count == $bits(rsp.entry_count)'(DEPTH)))
		else $error("full status below capacity");

	// an empty queue shows zero ends
	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.entry_count == '0) |->
		(rsp.front_word == '0) && (rsp.back_word == '0))
		else $error("empty queue shows nonzero ends");

endmodule

bind double_ended_queue_with_reverse deq_chk #(
	.DEPTH (DEPTH)
) u_deq_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);

// ===== dv/tb.sv =====
// tb: self-checking bench for double_ended_queue_with_reverse, driving random
// push, pop, reverse, clear and spare-code requests and checking every result against a mirror.
// Depends on deq_pkg, deq_if and the rtl top level.
module tb;
	import deq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 10;
	localparam int SLOTS      = DEPTH_DEF;
	localparam int WORD_W     = DATA_WIDTH_DEF;
	localparam int COUNT_W    = $clog2(DEPTH_DEF + 1);
	localparam int HOLD_CYCLES = 60;
	localparam int PHASE_ITEMS = 110;

	// request codes the block leaves alone
	localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

	typedef struct packed {
		logic signed [WORD_W-1:0] popped;
		logic [STATUS_W-1:0]      status;
		logic [COUNT_W-1:0]       count;
		logic signed [WORD_W-1:0] front;
		logic signed [WORD_W-1:0] back;
	} deq_result_t;

	// mirror of the ring, plus the results still owed by the block
	class deque_mirror;
		logic signed [WORD_W-1:0] slots [SLOTS];
		int          head;
		int          held;
		bit          flipped;
		deq_result_t owed[$];
		int          errors;

		function new();
			head    = 0;
			held    = 0;
			flipped = 1'b0;
			errors  = 0;
		endfunction

		function void note_request(logic [REQ_W-1:0] kind, logic signed [WORD_W-1:0] word);
			deq_result_t r;
			bit          near_end;
			logic signed [WORD_W-1:0] first, last;
			r = '0;
			first = '0;
			last = '0;
			case (kind)
				REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
					if (held >= SLOTS) begin
						r.status = ST_FULL;
					end else begin
						// front in logical terms is the physical start unless reversed
						near_end = (kind == REQ_PUSH_FRONT) != flipped;
						if (near_end) begin
							head = (head + SLOTS - 1) % SLOTS;
							slots[head] = word;
						end else begin
							slots[(head + held) % SLOTS] = word;
						end
						held++;
					end
				end
				REQ_POP_BACK, REQ_POP_FRONT: begin
					if (held == 0) begin
						r.status = ST_EMPTY;
					end else begin
						near_end = (kind == REQ_POP_FRONT) != flipped;
						if (near_end) begin
							r.popped = slots[head];
							head = (head + 1) % SLOTS;
						end else begin
							r.popped = slots[(head + held - 1) % SLOTS];
						end
						held--;
					end
				end
				REQ_REVERSE: begin
					flipped = !flipped;
				end
				REQ_CLEAR: begin
					held    = 0;
					head    = 0;
					flipped = 1'b0;
				end
				default: begin
				end
			endcase
			// ends as seen after the request
			if (held != 0) begin
				first = slots[head];
				last  = slots[(head + held - 1) % SLOTS];
			end
			r.count = held[COUNT_W-1:0];
			r.front = flipped ? last : first;
			r.back  = flipped ? first : last;
			r.status = r.status;
			owed.insert(owed.size(), r);
		endfunction

		function void compare_field(string name, logic [WORD_W-1:0] want,
			logic [WORD_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(deq_result_t got);
			deq_result_t want;
			if (owed.size() == 0) begin
				$display("%0t: result with none expected, actual %p", $time, got);
				errors++;
				return;
			end
			want = owed[0];
			owed.delete(0);
			compare_field("popped_word", want.popped, got.popped);
			compare_field("status", WORD_W'(want.status), WORD_W'(got.status));
			compare_field("entry_count", WORD_W'(want.count), WORD_W'(got.count));
			compare_field("front_word", want.front, got.front);
			compare_field("back_word", want.back, got.back);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   idle_on;
	bit   hold_pending;
	deque_mirror mirror;

	deq_req_if req_ch ();
	deq_rsp_if rsp_ch ();

	double_ended_queue_with_reverse dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// clock
	always #(CLK_PERIOD / 2) clk = ~clk;

	// transaction monitor: check results, then record new requests
	always @(posedge clk) begin
		deq_result_t seen;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen.popped = rsp_ch.popped_word;
				seen.status = rsp_ch.status;
				seen.count  = rsp_ch.entry_count;
				seen.front  = rsp_ch.front_word;
				seen.back   = rsp_ch.back_word;
				mirror.check_result(seen);
			end
			if (req_ch.valid && req_ch.ready)
				mirror.note_request(req_ch.req_type, req_ch.data_in);
		end
	end

	// result receiver: random stalls, plus one long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_pending = 1'b0;
			end else begin
				rsp_ch.ready <= !(idle_on && $urandom_range(99) < 15);
			end
		end
	end

	// one request transaction, with random gaps ahead of it while idling is on
	task automatic send_request(input logic [REQ_W-1:0] kind,
		input logic signed [WORD_W-1:0] word);
		if (idle_on) begin
			while ($urandom_range(99) < 15) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.data_in  <= word;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// word values lean on the extremes
	function automatic logic signed [WORD_W-1:0] pick_word();
		case ($urandom_range(9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	// request mix, pushes against pops weighted by push_pct
	function automatic logic [REQ_W-1:0] pick_kind(int push_pct);
		int r;
		r = $urandom_range(99);
		if (r < 2)
			return REQ_CLEAR;
		if (r < 4)
			return $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;
		if (r < 12)
			return REQ_REVERSE;
		if ($urandom_range(99) < push_pct)
			return $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
		return $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
	endfunction

	// stimulus and end of run
	initial begin
		int push_pct;
		mirror          = new();
		idle_on         = 1'b1;
		hold_pending    = 1'b0;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = REQ_PUSH_BACK;
		req_ch.data_in  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pops, reverse on short queues, extremes, spare codes, clear
		send_request(REQ_POP_BACK, 32'h1234_5678);
		send_request(REQ_POP_FRONT, '0);
		send_request(REQ_REVERSE, '0);
		send_request(REQ_PUSH_BACK, 32'h7fff_ffff);
		send_request(REQ_REVERSE, '0);
		send_request(REQ_PUSH_FRONT, 32'h8000_0000);
		send_request(REQ_PUSH_BACK, '1);
		send_request(REQ_PUSH_FRONT, '0);
		send_request(REQ_REVERSE, '0);
		send_request(REQ_POP_FRONT, '0);
		send_request(REQ_POP_BACK, '0);
		send_request(REQ_SPARE_LO, 32'hdead_beef);
		send_request(REQ_SPARE_HI, '1);
		send_request(REQ_PUSH_BACK, 32'h5a5a_5a5a);
		send_request(REQ_PUSH_FRONT, 32'ha5a5_a5a5);
		send_request(REQ_CLEAR, '0);
		send_request(REQ_POP_FRONT, '0);
		send_request(REQ_PUSH_FRONT, 32'h0000_0001);
		send_request(REQ_POP_BACK, '0);

		// random phases: filling, draining, balanced; one without idling, one with hold-off
		for (int p = 0; p < 6; p++) begin
			idle_on = (p != 2);
			if (p == 3)
				hold_pending = 1'b1;
			case (p % 3)
				0: push_pct = 80;
				1: push_pct = 25;
				default: push_pct = 50;
			endcase
			repeat (PHASE_ITEMS) send_request(pick_kind(push_pct), pick_word());
		end
		req_ch.valid <= 1'b0;
		// let the monitor record the last accepted request
		@(posedge clk);

		// drain outstanding results
		while (mirror.owed.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (mirror.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// run limit
	initial begin
		#1_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== double_ended_queue_with_reverse.f =====
rtl/deq_pkg.sv
rtl/deq_if.sv
rtl/deq_ram.sv
rtl/deq_dec.sv
rtl/deq_ring.sv
rtl/double_ended_queue_with_reverse.sv
rtl/deq_chk.sv
dv/tb.sv
